/* design/time_rule_specific_match_top_defines.svh */
// Assertion macros used by the schedule rule matcher controller.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TIME_RULE_SPECIFIC_MATCH_TOP_DEFINES_SVH
`define TIME_RULE_SPECIFIC_MATCH_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define TRSM_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error("trsm assertion failed");
`define TRSM_NEVER(lbl, clk_s, rst_n_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) \
		else $error("trsm forbidden condition seen");
`else
`define TRSM_ASSERT(lbl, clk_s, rst_n_s, prop)
`define TRSM_NEVER(lbl, clk_s, rst_n_s, cond)
`endif
`endif

/* design/trsm_pkg.sv */
// Types, constants and codes shared by the schedule rule matcher.
// Depends on nothing; used by trsm_ctrl, trsm_dp and the top level.
package trsm_pkg;

	localparam int RULES   = 32;
	localparam int ID_BITS = 8;
	localparam int IDX_W   = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int CNT_W   = $clog2(RULES + 1);
	localparam int COUNT_W = 6;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [4:0]  rule_index;
		logic [10:0] minute_a;
		logic [10:0] end_minute;
		logic [7:0]  day_bits;
		logic [3:0]  month_val;
		logic [4:0]  day_of_month;
		logic [11:0] year_val;
		logic [7:0]  event_id;
		logic [7:0]  group_id;
		logic [9:0]  script_id;
	} in_item_t;

	typedef struct packed {
		logic       found;
		logic [9:0] chosen_script;
	} out_item_t;

	typedef struct packed {
		logic [11:0] year_val;
		logic [4:0]  day_of_month;
		logic [3:0]  month_val;
		logic [7:0]  day_bits;
		logic [10:0] end_minute;
		logic [10:0] start_minute;
	} timing_t;

	typedef struct packed {
		logic [9:0]         script_id;
		logic [ID_BITS-1:0] group_id;
		logic [ID_BITS-1:0] event_id;
	} targets_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             wr_en;
		logic             start;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             load_out;
	} cmd_t;

	typedef struct packed {
		logic             n_zero;
		logic [IDX_W-1:0] last_idx;
		logic             out_free;
	} status_t;

endpackage

/* design/trsm_dp.sv */
// Datapath of the schedule rule matcher: rule tables, count register,
// per-rule match logic, pick state and output register. Uses trsm_pkg.
module trsm_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [5:0]              cfg_wdata,
	input  trsm_pkg::in_item_t      in_item,
	input  trsm_pkg::cmd_t          cmd,
	output trsm_pkg::status_t       status,
	output logic                    out_valid,
	input  logic                    out_stall,
	output trsm_pkg::out_item_t     out_item
);

	trsm_pkg::timing_t  timing_mem  [trsm_pkg::RULES];
	trsm_pkg::targets_t targets_mem [trsm_pkg::RULES];

	logic [trsm_pkg::COUNT_W-1:0] rule_count_q;
	logic [trsm_pkg::CNT_W-1:0]   n_eff;
	logic [trsm_pkg::CNT_W-1:0]   n_minus1;

	logic                         rd_valid_s1;
	trsm_pkg::timing_t            rd_timing_s1;
	trsm_pkg::targets_t           rd_targets_s1;

	logic [10:0]                  cur_q;
	logic [7:0]                   dbits_q;
	logic [3:0]                   mon_q;
	logic [4:0]                   dom_q;
	logic [11:0]                  yr_q;
	logic [trsm_pkg::ID_BITS-1:0] ev_q;
	logic [trsm_pkg::ID_BITS-1:0] gr_q;

	logic                         found_q;
	logic                         sel_days_q;
	logic                         sel_month_q;
	logic                         sel_year_q;
	logic                         sel_event_q;
	logic                         sel_group_q;
	logic [9:0]                   sel_script_q;

	logic                         out_valid_q;
	trsm_pkg::out_item_t          out_q;

	logic                         win_ok;
	logic                         uses;
	logic                         day_hit;
	logic                         hit;
	trsm_pkg::timing_t            wr_timing;
	trsm_pkg::targets_t           wr_targets;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q <= '0;
		end else if (cfg_we) begin
			rule_count_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (int'(rule_count_q) > trsm_pkg::RULES) begin
			n_eff = trsm_pkg::CNT_W'(trsm_pkg::RULES);
		end else begin
			n_eff = trsm_pkg::CNT_W'(rule_count_q);
		end
		n_minus1 = n_eff - trsm_pkg::CNT_W'(1);
	end

	assign status.n_zero   = (n_eff == '0);
	assign status.last_idx = n_minus1[trsm_pkg::IDX_W-1:0];
	assign status.out_free = !out_valid_q || !out_stall;

	always_comb begin
		wr_timing.year_val     = in_item.year_val;
		wr_timing.day_of_month = in_item.day_of_month;
		wr_timing.month_val    = in_item.month_val;
		wr_timing.day_bits     = in_item.day_bits;
		wr_timing.end_minute   = in_item.end_minute;
		wr_timing.start_minute = in_item.minute_a;
		wr_targets.script_id   = in_item.script_id;
		wr_targets.group_id    = trsm_pkg::ID_BITS'(in_item.group_id);
		wr_targets.event_id    = trsm_pkg::ID_BITS'(in_item.event_id);
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && (int'(in_item.rule_index) < trsm_pkg::RULES)) begin
			timing_mem[trsm_pkg::IDX_W'(in_item.rule_index)]  <= wr_timing;
			targets_mem[trsm_pkg::IDX_W'(in_item.rule_index)] <= wr_targets;
		end
		if (cmd.rd_en) begin
			rd_timing_s1  <= timing_mem[cmd.rd_addr];
			rd_targets_s1 <= targets_mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_q   <= in_item.minute_a;
			dbits_q <= in_item.day_bits;
			mon_q   <= in_item.month_val;
			dom_q   <= in_item.day_of_month;
			yr_q    <= in_item.year_val;
			ev_q    <= trsm_pkg::ID_BITS'(in_item.event_id);
			gr_q    <= trsm_pkg::ID_BITS'(in_item.group_id);
		end
	end

	always_comb begin
		if (rd_timing_s1.start_minute > rd_timing_s1.end_minute) begin
			win_ok = !((cur_q > rd_timing_s1.end_minute) &&
				(cur_q < rd_timing_s1.start_minute));
		end else begin
			win_ok = !((cur_q < rd_timing_s1.start_minute) ||
				(cur_q > rd_timing_s1.end_minute));
		end
		uses    = rd_timing_s1.day_bits[7];
		day_hit = (dbits_q < 8'd7) && rd_timing_s1.day_bits[dbits_q[2:0]];
		hit = win_ok
			&& !(sel_days_q && !uses)
			&& !(uses && !day_hit)
			&& !(sel_month_q && (rd_timing_s1.month_val == '0))
			&& !((rd_timing_s1.month_val != '0) &&
				((rd_timing_s1.month_val != mon_q) ||
				(rd_timing_s1.day_of_month != dom_q)))
			&& !(sel_year_q && (rd_timing_s1.year_val == '0))
			&& !((rd_timing_s1.year_val != '0) && (rd_timing_s1.year_val != yr_q))
			&& !(sel_event_q && (rd_targets_s1.event_id == '0))
			&& !((rd_targets_s1.event_id != '0) && (rd_targets_s1.event_id != ev_q))
			&& !(sel_group_q && (rd_targets_s1.group_id == '0))
			&& !((rd_targets_s1.group_id != '0) && (rd_targets_s1.group_id != gr_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			sel_days_q   <= 1'b0;
			sel_month_q  <= 1'b0;
			sel_year_q   <= 1'b0;
			sel_event_q  <= 1'b0;
			sel_group_q  <= 1'b0;
			sel_script_q <= '0;
		end else if (cmd.start) begin
			found_q      <= 1'b0;
			sel_days_q   <= 1'b0;
			sel_month_q  <= 1'b0;
			sel_year_q   <= 1'b0;
			sel_event_q  <= 1'b0;
			sel_group_q  <= 1'b0;
			sel_script_q <= '0;
		end else if (rd_valid_s1 && hit) begin
			found_q      <= 1'b1;
			sel_days_q   <= uses;
			sel_month_q  <= (rd_timing_s1.month_val != '0);
			sel_year_q   <= (rd_timing_s1.year_val != '0);
			sel_event_q  <= (rd_targets_s1.event_id != '0);
			sel_group_q  <= (rd_targets_s1.group_id != '0);
			sel_script_q <= rd_targets_s1.script_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.found         <= found_q;
			out_q.chosen_script <= sel_script_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* design/trsm_ctrl.sv */
// Controller of the schedule rule matcher: state machine and scan counter.
// Uses trsm_pkg and the assertion macros in the defines header.
`include "time_rule_specific_match_top_defines.svh"
module trsm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_opcode,
	output logic                 in_stall,
	input  trsm_pkg::status_t    status,
	output trsm_pkg::cmd_t       cmd
);

	trsm_pkg::state_t             state_q;
	trsm_pkg::state_t             state_nxt;
	logic [trsm_pkg::IDX_W-1:0]   idx_q;
	logic                         accept;

	assign in_stall = (state_q != trsm_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			trsm_pkg::ST_IDLE: begin
				if (accept && (in_opcode == trsm_pkg::OP_QUERY)) begin
					state_nxt = status.n_zero ? trsm_pkg::ST_FINISH : trsm_pkg::ST_SCAN;
				end
			end
			trsm_pkg::ST_SCAN: begin
				if (idx_q == status.last_idx) begin
					state_nxt = trsm_pkg::ST_DRAIN;
				end
			end
			trsm_pkg::ST_DRAIN: begin
				state_nxt = trsm_pkg::ST_FINISH;
			end
			trsm_pkg::ST_FINISH: begin
				if (status.out_free) begin
					state_nxt = trsm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = trsm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_addr = idx_q;
		case (state_q)
			trsm_pkg::ST_IDLE: begin
				cmd.wr_en = accept && (in_opcode == trsm_pkg::OP_WRITE);
				cmd.start = accept && (in_opcode == trsm_pkg::OP_QUERY);
			end
			trsm_pkg::ST_SCAN: begin
				cmd.rd_en = 1'b1;
			end
			trsm_pkg::ST_DRAIN: begin
				cmd.rd_en = 1'b0;
			end
			trsm_pkg::ST_FINISH: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trsm_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.start) begin
				idx_q <= '0;
			end else if (state_q == trsm_pkg::ST_SCAN) begin
				idx_q <= idx_q + trsm_pkg::IDX_W'(1);
			end
		end
	end

	`TRSM_ASSERT(a_start_scan, clk, arst_n, (cmd.start && !status.n_zero) |=> (state_q == trsm_pkg::ST_SCAN && idx_q == '0))
	`TRSM_ASSERT(a_read_in_range, clk, arst_n, cmd.rd_en |-> (cmd.rd_addr <= status.last_idx))
	`TRSM_NEVER(a_load_blocked, clk, arst_n, cmd.load_out && !status.out_free)
	`TRSM_ASSERT(a_drain_then_finish, clk, arst_n, (state_q == trsm_pkg::ST_DRAIN) |=> (state_q == trsm_pkg::ST_FINISH))

endmodule

/* design/time_rule_specific_match_top.sv */
// Schedule rule matcher: holds a table of timed rules and answers queries
// with the script of the most specific matching rule. The input channel takes
// write items (opcode 0) that load a rule and query items (opcode 1) that scan
// the table. Each channel uses valid and stall; an item moves at a clock edge
// with valid high and stall low. The rule_count register is written through
// cfg_we and cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce. A write item is taken and gives no
// result. A query reads one rule per cycle from the table memory, rules 0 to
// rule_count-1 (at most 32 rules), and the input stays stalled until its
// single result item has been loaded into the output register.
// The rule table read port sets this rate: one entry per cycle.
// The result waits in the output register while the receiver stalls; the
// next item is accepted meanwhile, but a query does not finish until the
// register is free. Reset clears the count to zero and empties the output;
// the rule table keeps no reset value and must be written before it is read.
module time_rule_specific_match_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [5:0]           cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  trsm_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output trsm_pkg::out_item_t  out_item
);

	trsm_pkg::cmd_t    cmd;
	trsm_pkg::status_t status;

	trsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (in_item.opcode),
		.in_stall  (in_stall),
		.status    (status),
		.cmd       (cmd)
	);

	trsm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
